FILE: sv/shac_pkg.sv
// ----------------------------------------------------------------------------
// shac_pkg: shared types and constants of the homing controller
// Action codes, status codes, beat and result types, register reset values.
// ----------------------------------------------------------------------------
package shac_pkg;

   localparam int unsigned HLIMIT_W  = 15;
   localparam int unsigned DEBOUNCE_W = 16;
   localparam int unsigned HSTEP_W   = 15;
   localparam int unsigned POS_W     = 16;
   localparam int unsigned STEPS_W   = 16;
   localparam int unsigned CSR_W     = 16;
   localparam int unsigned CSR_ADDR_W = 2;

   localparam logic [1:0] ACT_TICK     = 2'd0;
   localparam logic [1:0] ACT_MOVE     = 2'd1;
   localparam logic [1:0] ACT_SHUTDOWN = 2'd2;

   localparam logic [1:0] ST_BUSY  = 2'd0;
   localparam logic [1:0] ST_CLEAR = 2'd1;
   localparam logic [1:0] ST_READY = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_HEIGHT_LIMIT   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DEBOUNCE_TICKS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_HOME_STEP      = 2'd2;

   localparam logic [HLIMIT_W-1:0]   HLIMIT_RST   = 15'd32766;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd1000;
   localparam logic [HSTEP_W-1:0]    HSTEP_RST    = 15'd100;

   typedef struct packed {
      logic [1:0]       action;
      logic [POS_W-1:0] target_pos;
      logic             limit_switch_hit;
      logic             motor_arrived;
   } item_type;

   typedef struct packed {
      logic               motor_cmd_valid;
      logic [STEPS_W-1:0] motor_steps;
      logic [1:0]         status;
      logic               position_known;
      logic               outputs_off;
      logic               motor_off;
      logic               limit_led;
   } result_type;

endpackage

FILE: sv/shac_core.sv
// ----------------------------------------------------------------------------
// shac_core: axis state and per-beat step logic
// Holds the control registers and axis state; computes one result per beat
// and commits the state update when the beat fires.
// ----------------------------------------------------------------------------
module shac_core
   import shac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata,
   input  logic                  fire,
   input  item_type              item,
   output result_type            result
);

   typedef enum logic [2:0] {
      MODE_INIT,
      MODE_IDLE,
      MODE_HOME,
      MODE_DEBOUNCE,
      MODE_MOVE,
      MODE_MOVE_WAIT
   } mode_type;

   logic [HLIMIT_W-1:0]   hlimit_ff;
   logic [DEBOUNCE_W-1:0] dticks_ff;
   logic [HSTEP_W-1:0]    hstep_ff;

   mode_type              mode_ff, mode_in;
   logic [HLIMIT_W-1:0]   target_ff, target_in;
   logic [HLIMIT_W-1:0]   cur_ff, cur_in;
   logic                  homed_ff, homed_in;
   logic [DEBOUNCE_W-1:0] count_ff, count_in;
   logic [1:0]            status_ff, status_in;

   logic [DEBOUNCE_W-1:0] count_inc;

   assign count_inc = (count_ff == {DEBOUNCE_W{1'b1}}) ? count_ff : count_ff + 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      target_in = target_ff;
      cur_in    = cur_ff;
      homed_in  = homed_ff;
      count_in  = count_ff;
      status_in = status_ff;
      result    = '0;
      result.limit_led = item.limit_switch_hit;
      case (item.action)
         ACT_MOVE: begin
            status_in = ST_CLEAR;
            if (item.target_pos == '0) begin
               target_in = '0;
               mode_in   = MODE_HOME;
            end else begin
               target_in = (item.target_pos < {1'b0, hlimit_ff}) ?
                           item.target_pos[HLIMIT_W-1:0] : hlimit_ff;
               mode_in   = MODE_MOVE;
            end
         end
         ACT_SHUTDOWN: begin
            result.motor_off = 1'b1;
            homed_in = 1'b0;
         end
         ACT_TICK: begin
            case (mode_ff)
               MODE_INIT: begin
                  result.outputs_off = 1'b1;
                  status_in = ST_CLEAR;
                  target_in = '0;
                  mode_in   = MODE_HOME;
               end
               MODE_HOME: begin
                  if (item.motor_arrived) begin
                     if (item.limit_switch_hit) begin
                        mode_in  = MODE_DEBOUNCE;
                        count_in = '0;
                     end else begin
                        result.motor_cmd_valid = 1'b1;
                        result.motor_steps = {{(STEPS_W-HSTEP_W){1'b0}}, hstep_ff};
                     end
                  end
               end
               MODE_DEBOUNCE: begin
                  count_in = count_inc;
                  if (count_inc >= dticks_ff) begin
                     result.motor_cmd_valid = 1'b1;
                     homed_in = 1'b1;
                     cur_in   = '0;
                     if (target_ff != '0) begin
                        mode_in = MODE_MOVE;
                     end else begin
                        mode_in   = MODE_IDLE;
                        status_in = ST_READY;
                     end
                  end else if (!item.limit_switch_hit) begin
                     mode_in = MODE_HOME;
                  end
               end
               MODE_MOVE: begin
                  if (!homed_ff) begin
                     mode_in = MODE_HOME;
                  end else if (target_ff == cur_ff) begin
                     mode_in   = MODE_IDLE;
                     status_in = ST_READY;
                  end else begin
                     result.motor_cmd_valid = 1'b1;
                     result.motor_steps = {1'b0, cur_ff} - {1'b0, target_ff};
                     mode_in = MODE_MOVE_WAIT;
                  end
               end
               MODE_MOVE_WAIT: begin
                  if (item.motor_arrived) begin
                     result.motor_cmd_valid = 1'b1;
                     cur_in    = target_ff;
                     mode_in   = MODE_IDLE;
                     status_in = ST_READY;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      result.status         = status_in;
      result.position_known = homed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hlimit_ff <= HLIMIT_RST;
         dticks_ff <= DEBOUNCE_RST;
         hstep_ff  <= HSTEP_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_HEIGHT_LIMIT:   hlimit_ff <= csr_wdata[HLIMIT_W-1:0];
            REG_DEBOUNCE_TICKS: dticks_ff <= csr_wdata[DEBOUNCE_W-1:0];
            REG_HOME_STEP:      hstep_ff  <= csr_wdata[HSTEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_INIT;
         target_ff <= '0;
         cur_ff    <= '0;
         homed_ff  <= 1'b0;
         count_ff  <= '0;
         status_ff <= ST_BUSY;
      end else if (fire) begin
         mode_ff   <= mode_in;
         target_ff <= target_in;
         cur_ff    <= cur_in;
         homed_ff  <= homed_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

endmodule

FILE: sv/stepper_axis_homing_controller.sv
// ----------------------------------------------------------------------------
// stepper_axis_homing_controller: elevator axis homing and move control
// A taken request beat is held in the request register; its result beat is
// captured in the result register when the beat fires. One beat per cycle
// unless the result side stalls. Synchronous active-high reset empties both
// stages, restores register defaults and puts the axis in init mode.
// ----------------------------------------------------------------------------
module stepper_axis_homing_controller
   import shac_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic [POS_W-1:0]          req_target_pos,
   input  logic                      req_limit_switch_hit,
   input  logic                      req_motor_arrived,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_motor_cmd_valid,
   output logic signed [STEPS_W-1:0] rsp_motor_steps,
   output logic [1:0]                rsp_status,
   output logic                      rsp_position_known,
   output logic                      rsp_outputs_off,
   output logic                      rsp_motor_off,
   output logic                      rsp_limit_led,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_W-1:0]     csr_addr,
   input  logic [CSR_W-1:0]          csr_wdata
);

   logic       s1_valid_ff;
   item_type   s1_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   logic       out_en;
   logic       fire;

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && out_en;
   assign req_ready = !s1_valid_ff || out_en;

   shac_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (s1_item_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_en) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff.action           <= req_action;
         s1_item_ff.target_pos       <= req_target_pos;
         s1_item_ff.limit_switch_hit <= req_limit_switch_hit;
         s1_item_ff.motor_arrived    <= req_motor_arrived;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_motor_cmd_valid = rsp_ff.motor_cmd_valid;
   assign rsp_motor_steps     = $signed(rsp_ff.motor_steps);
   assign rsp_status          = rsp_ff.status;
   assign rsp_position_known  = rsp_ff.position_known;
   assign rsp_outputs_off     = rsp_ff.outputs_off;
   assign rsp_motor_off       = rsp_ff.motor_off;
   assign rsp_limit_led       = rsp_ff.limit_led;

endmodule

FILE: sv/shac_checker.sv
// ----------------------------------------------------------------------------
// shac_checker: port-level checks of the homing controller
// Watches the result channel for stall stability and result consistency.
// ----------------------------------------------------------------------------
module shac_checker
   import shac_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_motor_cmd_valid,
   input logic signed [STEPS_W-1:0] rsp_motor_steps,
   input logic [1:0]                rsp_status,
   input logic                      rsp_outputs_off,
   input logic                      rsp_motor_off
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_motor_steps))
      else $error("stalled result beat changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_BUSY || rsp_status == ST_CLEAR ||
                     rsp_status == ST_READY))
      else $error("bad status code");

   a_steps_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_motor_cmd_valid |-> rsp_motor_steps == '0)
      else $error("steps nonzero without a move order");

   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outputs_off |-> !rsp_motor_off && !rsp_motor_cmd_valid)
      else $error("init switch-off beat carries another order");

endmodule

bind stepper_axis_homing_controller shac_checker u_shac_checker (.*);

FILE: dv/shac_axis_checker.sv
// ----------------------------------------------------------------------------
// shac_axis_checker: response predictor and scoreboard for the homing axis
// Tracks register writes and every accepted request beat, runs its own model
// of the axis mode logic, and checks each accepted response beat field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module shac_axis_checker
   import shac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [POS_W-1:0]      req_target_pos,
   input  logic                  req_limit_switch_hit,
   input  logic                  req_motor_arrived,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_motor_cmd_valid,
   input  logic [STEPS_W-1:0]    rsp_motor_steps,
   input  logic [1:0]            rsp_status,
   input  logic                  rsp_position_known,
   input  logic                  rsp_outputs_off,
   input  logic                  rsp_motor_off,
   input  logic                  rsp_limit_led,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   typedef enum logic [2:0] {
      AX_INIT,
      AX_IDLE,
      AX_HOMING,
      AX_DEBOUNCE,
      AX_MOVE,
      AX_MOVE_WAIT
   } axis_mode_type;

   logic [HLIMIT_W-1:0]   height_limit;
   logic [DEBOUNCE_W-1:0] debounce_ticks;
   logic [HSTEP_W-1:0]    home_step;

   axis_mode_type         mode;
   logic [POS_W-1:0]      target_q;
   logic [POS_W-1:0]      position_q;
   logic                  homed;
   logic [DEBOUNCE_W-1:0] settle_count;
   logic [1:0]            status_q;

   result_type            axis_replies_q[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic void settle_ready();
      status_q = ST_READY;
      mode     = AX_IDLE;
   endfunction

   function automatic void start_travel(logic [POS_W-1:0] pos);
      status_q = ST_CLEAR;
      if (pos == '0) begin
         target_q = '0;
         mode     = AX_HOMING;
      end else begin
         target_q = (pos < {1'b0, height_limit}) ? pos : {1'b0, height_limit};
         mode     = AX_MOVE;
      end
   endfunction

   function automatic result_type advance_axis(item_type it);
      result_type r;
      r           = '0;
      r.limit_led = it.limit_switch_hit;
      case (it.action)
         ACT_MOVE: begin
            start_travel(it.target_pos);
         end
         ACT_SHUTDOWN: begin
            r.motor_off = 1'b1;
            homed       = 1'b0;
         end
         ACT_TICK: begin
            case (mode)
               AX_INIT: begin
                  r.outputs_off = 1'b1;
                  start_travel('0);
               end
               AX_HOMING: begin
                  if (it.motor_arrived && it.limit_switch_hit) begin
                     mode         = AX_DEBOUNCE;
                     settle_count = '0;
                  end else if (it.motor_arrived) begin
                     r.motor_cmd_valid = 1'b1;
                     r.motor_steps     = {1'b0, home_step};
                  end
               end
               AX_DEBOUNCE: begin
                  if (settle_count != '1)
                     settle_count = settle_count + 1'b1;
                  if (settle_count >= debounce_ticks) begin
                     r.motor_cmd_valid = 1'b1;
                     homed             = 1'b1;
                     position_q        = '0;
                     if (target_q != position_q)
                        mode = AX_MOVE;
                     else
                        settle_ready();
                  end else if (!it.limit_switch_hit) begin
                     mode = AX_HOMING;
                  end
               end
               AX_MOVE: begin
                  if (!homed) begin
                     mode = AX_HOMING;
                  end else if (target_q == position_q) begin
                     settle_ready();
                  end else begin
                     r.motor_cmd_valid = 1'b1;
                     r.motor_steps     = position_q - target_q;
                     mode              = AX_MOVE_WAIT;
                  end
               end
               AX_MOVE_WAIT: begin
                  if (it.motor_arrived) begin
                     r.motor_cmd_valid = 1'b1;
                     position_q        = target_q;
                     settle_ready();
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.status         = status_q;
      r.position_known = homed;
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      item_type   beat;
      if (reset) begin
         height_limit   = HLIMIT_RST;
         debounce_ticks = DEBOUNCE_RST;
         home_step      = HSTEP_RST;
         mode           = AX_INIT;
         target_q       = '0;
         position_q     = '0;
         homed          = 1'b0;
         settle_count   = '0;
         status_q       = ST_BUSY;
         axis_replies_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_HEIGHT_LIMIT:   height_limit   = csr_wdata[HLIMIT_W-1:0];
               REG_DEBOUNCE_TICKS: debounce_ticks = csr_wdata[DEBOUNCE_W-1:0];
               REG_HOME_STEP:      home_step      = csr_wdata[HSTEP_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (axis_replies_q.size() == 0) begin
               $error("response beat with no prediction waiting");
               fail_count++;
            end else begin
               want = axis_replies_q.pop_front();
               check_field("motor_cmd_valid", want.motor_cmd_valid, rsp_motor_cmd_valid);
               check_field("motor_steps", int'($signed(want.motor_steps)),
                           int'($signed(rsp_motor_steps)));
               check_field("status", want.status, rsp_status);
               check_field("position_known", want.position_known, rsp_position_known);
               check_field("outputs_off", want.outputs_off, rsp_outputs_off);
               check_field("motor_off", want.motor_off, rsp_motor_off);
               check_field("limit_led", want.limit_led, rsp_limit_led);
            end
         end
         if (req_valid && req_ready) begin
            beat.action           = req_action;
            beat.target_pos       = req_target_pos;
            beat.limit_switch_hit = req_limit_switch_hit;
            beat.motor_arrived    = req_motor_arrived;
            axis_replies_q.push_back(advance_axis(beat));
         end
      end
      outstanding <= axis_replies_q.size();
   end

endmodule

FILE: dv/tb_stepper_axis_homing_controller.sv
// ----------------------------------------------------------------------------
// tb_stepper_axis_homing_controller: regression bench for the homing axis
// Directed beats walk through init, homing, debounce, clamped moves, shutdown
// and an unused action code; then register sweeps drive random tick and
// command traffic with a sticky limit switch, bursty requests and a
// stalling response side. The checker module scores every response beat.
// ----------------------------------------------------------------------------
module tb_stepper_axis_homing_controller;
   import shac_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int         RANDOM_BEATS = 850;
   localparam int         HOLD_OFF_CYCLES = 300;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_action = ACT_TICK;
   logic [POS_W-1:0]          req_target_pos = '0;
   logic                      req_limit_switch_hit = 1'b0;
   logic                      req_motor_arrived = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_motor_cmd_valid;
   logic signed [STEPS_W-1:0] rsp_motor_steps;
   logic [1:0]                rsp_status;
   logic                      rsp_position_known;
   logic                      rsp_outputs_off;
   logic                      rsp_motor_off;
   logic                      rsp_limit_led;
   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_addr = '0;
   logic [CSR_W-1:0]          csr_wdata = '0;
   int                        fail_count;
   int                        outstanding;

   int                        burst_left = 0;
   int                        hold_off_asks = 0;
   logic [HLIMIT_W-1:0]       hlimit_now = HLIMIT_RST;

   stepper_axis_homing_controller dut (.*);

   shac_axis_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // response side: segments of varying stall density, plus requested hold-offs
   initial begin
      int served;
      int seg;
      int pct;
      served = 0;
      forever begin
         if (hold_off_asks != served) begin
            served = hold_off_asks;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         seg = $urandom_range(8, 48);
         case ($urandom_range(0, 2))
            0:       pct = 100;
            1:       pct = 70;
            default: pct = 25;
         endcase
         repeat (seg) begin
            rsp_ready <= ($urandom_range(1, 100) <= pct);
            @(posedge clock);
         end
      end
   end

   task automatic offer_beat(input logic [1:0] act, input logic [POS_W-1:0] pos,
                             input logic sw, input logic arr);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid            <= 1'b1;
      req_action           <= act;
      req_target_pos       <= pos;
      req_limit_switch_hit <= sw;
      req_motor_arrived    <= arr;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_axis();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic program_axis(input logic [HLIMIT_W-1:0] hl,
                               input logic [DEBOUNCE_W-1:0] db,
                               input logic [HSTEP_W-1:0] hs);
      csr_we    <= 1'b1;
      csr_addr  <= REG_HEIGHT_LIMIT;
      csr_wdata <= CSR_W'(hl);
      @(posedge clock);
      csr_addr  <= REG_DEBOUNCE_TICKS;
      csr_wdata <= CSR_W'(db);
      @(posedge clock);
      csr_addr  <= REG_HOME_STEP;
      csr_wdata <= CSR_W'(hs);
      @(posedge clock);
      csr_we    <= 1'b0;
      hlimit_now = hl;
   endtask

   initial begin
      int                    sent;
      int                    phase;
      int                    n;
      int                    pick;
      logic                  switch_closed;
      logic [1:0]            act;
      logic [POS_W-1:0]      pos;
      logic [HLIMIT_W-1:0]   hl;
      logic [DEBOUNCE_W-1:0] db;
      logic [HSTEP_W-1:0]    hs;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset defaults, init, homing steps, unused code, shutdown
      offer_beat(ACT_UNUSED, 16'h0000, 1'b0, 1'b1);
      offer_beat(ACT_TICK, 16'hFFFF, 1'b0, 1'b1);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b0);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b1);
      offer_beat(ACT_SHUTDOWN, 16'h0000, 1'b1, 1'b0);
      drain_axis();

      // directed: minimum limit and debounce, maximum home step
      program_axis(15'd1, 16'd1, 15'd32767);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b1);
      offer_beat(ACT_TICK, 16'h0000, 1'b1, 1'b1);
      offer_beat(ACT_TICK, 16'h0000, 1'b1, 1'b1);
      offer_beat(ACT_TICK, 16'h0000, 1'b1, 1'b0);
      offer_beat(ACT_MOVE, 16'hFFFF, 1'b0, 1'b0);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b1);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b0);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b1);
      offer_beat(ACT_MOVE, 16'h0000, 1'b0, 1'b1);
      offer_beat(ACT_SHUTDOWN, 16'h0000, 1'b0, 1'b1);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b1);
      offer_beat(ACT_TICK, 16'h0000, 1'b1, 1'b1);
      // count reaches the threshold before the open switch is looked at
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b1);
      drain_axis();

      // directed: full-range moves up and down, shutdown during a move
      program_axis(15'd32766, 16'd2, 15'd1);
      offer_beat(ACT_MOVE, 16'd32767, 1'b0, 1'b0);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b0);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b1);
      offer_beat(ACT_MOVE, 16'd1, 1'b0, 1'b0);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b0);
      offer_beat(ACT_SHUTDOWN, 16'h0000, 1'b0, 1'b0);
      offer_beat(ACT_TICK, 16'h0000, 1'b0, 1'b1);
      drain_axis();

      // random sweeps over register settings
      sent          = 0;
      phase         = 0;
      switch_closed = 1'b0;
      while (sent < RANDOM_BEATS) begin
         case (phase)
            0: begin
               hl = 15'd1;
               db = 16'd65535;
               hs = 15'd1;
            end
            1: begin
               hl = 15'd32766;
               db = 16'd1;
               hs = 15'd32767;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       hl = 15'd1;
                  1:       hl = 15'd32766;
                  2:       hl = HLIMIT_W'($urandom_range(1, 300));
                  default: hl = HLIMIT_W'($urandom_range(1, 32766));
               endcase
               pick = $urandom_range(0, 9);
               if (pick == 0)
                  db = 16'd65535;
               else if (pick < 3)
                  db = 16'd1;
               else if (pick < 7)
                  db = DEBOUNCE_W'($urandom_range(2, 6));
               else
                  db = DEBOUNCE_W'($urandom_range(1, 30));
               case ($urandom_range(0, 3))
                  0:       hs = 15'd1;
                  1:       hs = 15'd32767;
                  2:       hs = HSTEP_W'($urandom_range(1, 500));
                  default: hs = HSTEP_W'($urandom_range(1, 32767));
               endcase
            end
         endcase
         program_axis(hl, db, hs);
         if (phase == 2)
            hold_off_asks <= hold_off_asks + 1;
         n = $urandom_range(50, 110);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0)
               switch_closed = ~switch_closed;
            pos  = POS_W'($urandom_range(0, 16'hFFFF));
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               act = ACT_MOVE;
               case ($urandom_range(0, 5))
                  0:       pos = '0;
                  1:       pos = {1'b0, hlimit_now};
                  2:       pos = {1'b0, hlimit_now} + 1'b1;
                  3:       pos = POS_W'($urandom_range(1, {1'b0, hlimit_now}));
                  default: ;
               endcase
            end else if (pick < 12) begin
               act = ACT_SHUTDOWN;
            end else begin
               act = ACT_TICK;
            end
            offer_beat(act, pos, switch_closed, $urandom_range(0, 3) != 0);
            sent++;
         end
         drain_axis();
         phase++;
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: stepper_axis_homing_controller.f
sv/shac_pkg.sv
sv/shac_core.sv
sv/stepper_axis_homing_controller.sv
sv/shac_checker.sv
dv/shac_axis_checker.sv
dv/tb_stepper_axis_homing_controller.sv
